### hw/rtl/i2cram_pkg.sv
`default_nettype none
package i2cram_pkg;

  localparam int unsigned PhaseWidth  = 16;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned InTdataW    = 32;
  localparam int unsigned OutTdataW   = 16;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [PhaseWidth-1:0] PhaseTicksReset = 16'd3;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [StatusWidth-1:0] STAT_OK        = 3'd0;
  localparam logic [StatusWidth-1:0] STAT_BUS_LOW   = 3'd1;
  localparam logic [StatusWidth-1:0] STAT_NO_START  = 3'd2;
  localparam logic [StatusWidth-1:0] STAT_DEV_NACK  = 3'd3;
  localparam logic [StatusWidth-1:0] STAT_REG_NACK  = 3'd4;
  localparam logic [StatusWidth-1:0] STAT_DATA_NACK = 3'd5;

  localparam logic [7:0] DirMask = 8'hFE;
  localparam logic [7:0] DirRead = 8'h01;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_S_HI,
    ST_S_LO,
    ST_S_HOLD,
    ST_TX_CLK_LO,
    ST_TX_DATA,
    ST_TX_CLK_HI,
    ST_ACK_CLK_LO,
    ST_ACK_REL,
    ST_ACK_CLK_HI,
    ST_R_HI,
    ST_R_LO,
    ST_R_HOLD,
    ST_RX_LOW,
    ST_RX_HIGH,
    ST_NK_LOW,
    ST_NK_REL,
    ST_NK_HIGH,
    ST_NK_END,
    ST_P_LOW,
    ST_P_SDA,
    ST_P_HIGH,
    ST_P_END
  } state_t;

  typedef enum logic [1:0] {
    BYTE_DEVICE,
    BYTE_REGISTER,
    BYTE_LAST
  } byte_sel_t;

endpackage
`default_nettype wire

### hw/rtl/i2c_register_access_master.sv
// I2C register access master with open-drain pin controls. Each stream transfer is one
// bus tick: it carries the sampled SDA level and an optional request (register write or
// register read), and yields exactly one result transfer with the SCL/SDA release levels,
// busy, done, status and the last read byte. One transfer is taken every clock cycle while
// the result side keeps up; the result register sits between the two sides, so a new tick
// is accepted while the previous result is being taken. Each bus phase lasts phase_ticks
// ticks (APB register at address 0, reset 3, 0 acts as 1); after the request tick a full
// write runs 88 phases and a successful read 111.
`default_nettype none
module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // operation[1:0], device_address[9:2], register_address[17:10], write_data[25:18],
  // sda_in[26], zero[31:27]
  input  wire logic [InTdataW-1:0]   s_axis_tdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // scl_release[0], sda_release[1], busy_res[2], done_res[3], status[6:4],
  // read_data[14:7], zero[15]
  output logic [OutTdataW-1:0]       m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ApbAddrW-1:0]   paddr,
  input  wire logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]        prdata,
  output logic                       pready
);

  logic [PhaseWidth-1:0]  phase_ticks;
  state_t                 state, state_next;
  byte_sel_t              byte_sel, byte_sel_next;
  logic [PhaseWidth-1:0]  phase_counter, phase_counter_next;
  logic [3:0]             bit_counter, bit_counter_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   is_read, is_read_next;
  logic [7:0]             held_device, held_device_next;
  logic [7:0]             held_register, held_register_next;
  logic [7:0]             held_data, held_data_next;
  logic [7:0]             last_read, last_read_next;
  logic                   scl_level, scl_level_next;
  logic                   sda_level, sda_level_next;
  logic [StatusWidth-1:0] last_status, last_status_next;
  logic                   done_next;
  logic [OutTdataW-1:0]   m_axis_tdata_next;

  logic                   s_accept;
  logic [PhaseWidth-1:0]  phase_len;
  logic [1:0]             in_op;
  logic [7:0]             in_device, in_register, in_data;
  logic                   in_sda;

  assign in_op       = s_axis_tdata[1:0];
  assign in_device   = s_axis_tdata[9:2];
  assign in_register = s_axis_tdata[17:10];
  assign in_data     = s_axis_tdata[25:18];
  assign in_sda      = s_axis_tdata[26];

  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign phase_len     = (phase_ticks == '0) ? PhaseWidth'(1) : phase_ticks;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? ApbDataW'(phase_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PhaseTicksReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      phase_ticks <= pwdata[PhaseWidth-1:0];
    end
  end

  // next state
  always_comb begin
    logic                  do_enter;
    state_t                enter_s;
    logic [PhaseWidth-1:0] pc_inc;
    logic [3:0]            bc_inc;
    logic [7:0]            dev2;

    state_next         = state;
    byte_sel_next      = byte_sel;
    phase_counter_next = phase_counter;
    bit_counter_next   = bit_counter;
    shift_byte_next    = shift_byte;
    is_read_next       = is_read;
    held_device_next   = held_device;
    held_register_next = held_register;
    held_data_next     = held_data;
    last_read_next     = last_read;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    last_status_next   = last_status;
    done_next          = 1'b0;
    do_enter           = 1'b0;
    enter_s            = state;
    pc_inc             = phase_counter + PhaseWidth'(1);
    bc_inc             = bit_counter + 4'd1;
    dev2               = (held_device & DirMask) | DirRead;

    if (s_accept) begin
      if (state == ST_IDLE) begin
        if (in_op == OP_WRITE || in_op == OP_READ) begin
          held_device_next   = in_device;
          held_register_next = in_register;
          held_data_next     = in_data;
          is_read_next       = (in_op == OP_READ);
          last_status_next   = STAT_OK;
          do_enter           = 1'b1;
          enter_s            = ST_S_HI;
        end
      end else begin
        phase_counter_next = pc_inc;
        if (pc_inc >= phase_len) begin
          do_enter = 1'b1;
          case (state)
            ST_S_HI: begin
              if (!in_sda) begin
                last_status_next = STAT_BUS_LOW;
                state_next       = ST_IDLE;
                done_next        = 1'b1;
                do_enter         = 1'b0;
              end else begin
                enter_s = ST_S_LO;
              end
            end
            ST_S_LO: begin
              if (in_sda) begin
                last_status_next = STAT_NO_START;
                state_next       = ST_IDLE;
                done_next        = 1'b1;
                do_enter         = 1'b0;
              end else begin
                enter_s = ST_S_HOLD;
              end
            end
            ST_S_HOLD: begin
              shift_byte_next  = held_device & DirMask;
              bit_counter_next = '0;
              byte_sel_next    = BYTE_DEVICE;
              enter_s          = ST_TX_CLK_LO;
            end
            ST_TX_CLK_LO:  enter_s = ST_TX_DATA;
            ST_TX_DATA:    enter_s = ST_TX_CLK_HI;
            ST_TX_CLK_HI: begin
              bit_counter_next = bc_inc;
              enter_s          = bc_inc[3] ? ST_ACK_CLK_LO : ST_TX_CLK_LO;
            end
            ST_ACK_CLK_LO: enter_s = ST_ACK_REL;
            ST_ACK_REL:    enter_s = ST_ACK_CLK_HI;
            ST_ACK_CLK_HI: begin
              case (byte_sel)
                BYTE_DEVICE: begin
                  if (in_sda) begin
                    last_status_next = STAT_DEV_NACK;
                    enter_s          = ST_P_LOW;
                  end else begin
                    shift_byte_next  = held_register;
                    bit_counter_next = '0;
                    byte_sel_next    = BYTE_REGISTER;
                    enter_s          = ST_TX_CLK_LO;
                  end
                end
                BYTE_REGISTER: begin
                  if (is_read) begin
                    enter_s = ST_R_HI;
                  end else if (in_sda) begin
                    last_status_next = STAT_REG_NACK;
                    enter_s          = ST_P_LOW;
                  end else begin
                    shift_byte_next  = held_data;
                    bit_counter_next = '0;
                    byte_sel_next    = BYTE_LAST;
                    enter_s          = ST_TX_CLK_LO;
                  end
                end
                default: begin
                  if (is_read) begin
                    shift_byte_next  = '0;
                    bit_counter_next = '0;
                    enter_s          = ST_RX_LOW;
                  end else begin
                    last_status_next = in_sda ? STAT_DATA_NACK : STAT_OK;
                    enter_s          = ST_P_LOW;
                  end
                end
              endcase
            end
            ST_R_HI, ST_R_LO, ST_R_HOLD: begin
              if ((state == ST_R_HI && in_sda) || (state == ST_R_LO && !in_sda)) begin
                enter_s = (state == ST_R_HI) ? ST_R_LO : ST_R_HOLD;
              end else begin
                shift_byte_next  = dev2;
                bit_counter_next = '0;
                byte_sel_next    = BYTE_LAST;
                enter_s          = ST_TX_CLK_LO;
              end
            end
            ST_RX_LOW: enter_s = ST_RX_HIGH;
            ST_RX_HIGH: begin
              shift_byte_next  = {shift_byte[6:0], in_sda};
              bit_counter_next = bc_inc;
              enter_s          = bc_inc[3] ? ST_NK_LOW : ST_RX_LOW;
            end
            ST_NK_LOW:  enter_s = ST_NK_REL;
            ST_NK_REL:  enter_s = ST_NK_HIGH;
            ST_NK_HIGH: enter_s = ST_NK_END;
            ST_NK_END: begin
              last_status_next = STAT_OK;
              enter_s          = ST_P_LOW;
            end
            ST_P_LOW:  enter_s = ST_P_SDA;
            ST_P_SDA:  enter_s = ST_P_HIGH;
            ST_P_HIGH: enter_s = ST_P_END;
            ST_P_END: begin
              if (is_read && last_status == STAT_OK) begin
                last_read_next = shift_byte;
              end
              state_next = ST_IDLE;
              done_next  = 1'b1;
              do_enter   = 1'b0;
            end
            default: begin
              state_next = ST_IDLE;
              done_next  = 1'b1;
              do_enter   = 1'b0;
            end
          endcase
        end
      end
    end

    // pin levels change on entry to a phase
    if (do_enter) begin
      state_next         = enter_s;
      phase_counter_next = '0;
      case (enter_s)
        ST_S_HI, ST_R_HI: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
        end
        ST_S_LO, ST_R_LO, ST_P_SDA: sda_level_next = 1'b0;
        ST_TX_DATA: begin
          sda_level_next  = shift_byte_next[7];
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
        end
        ST_RX_LOW: begin
          scl_level_next = 1'b0;
          sda_level_next = 1'b1;
        end
        ST_TX_CLK_LO, ST_ACK_CLK_LO, ST_NK_LOW, ST_NK_END, ST_P_LOW: scl_level_next = 1'b0;
        ST_TX_CLK_HI, ST_ACK_CLK_HI, ST_RX_HIGH, ST_NK_HIGH, ST_P_HIGH: scl_level_next = 1'b1;
        ST_ACK_REL, ST_NK_REL, ST_P_END: sda_level_next = 1'b1;
        default: ;
      endcase
    end
  end

  // result
  always_comb begin
    m_axis_tdata_next = {1'b0, last_read_next, last_status_next, done_next,
                         (state_next != ST_IDLE), sda_level_next, scl_level_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      byte_sel      <= BYTE_DEVICE;
      phase_counter <= '0;
      bit_counter   <= '0;
      shift_byte    <= '0;
      is_read       <= 1'b0;
      held_device   <= '0;
      held_register <= '0;
      held_data     <= '0;
      last_read     <= '0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      last_status   <= STAT_OK;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      byte_sel      <= byte_sel_next;
      phase_counter <= phase_counter_next;
      bit_counter   <= bit_counter_next;
      shift_byte    <= shift_byte_next;
      is_read       <= is_read_next;
      held_device   <= held_device_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
      last_read     <= last_read_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      last_status   <= last_status_next;
      if (s_axis_tready) begin
        m_axis_tvalid <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_axis_tdata <= m_axis_tdata_next;
    end
  end

  a_start_enters_s_hi: assert property (@(posedge clk) disable iff (rst)
    (s_accept && state == ST_IDLE && (in_op == OP_WRITE || in_op == OP_READ))
    |=> (state == ST_S_HI))
    else $error("request in idle did not start the bus sequence");

  a_hold_without_transfer: assert property (@(posedge clk) disable iff (rst)
    (!s_accept) |=> ($stable(state) && $stable(phase_counter)))
    else $error("sequencer moved without an input transfer");

  a_scl_released_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> scl_level)
    else $error("SCL pulled low while idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    (bit_counter <= 4'd8))
    else $error("bit counter out of range");

endmodule
`default_nettype wire
